// ===== rtl/tnf_pkg.sv =====
// Shared constants, request/response types and rounding helpers for the
// tunable notch filter. No dependencies.
package tnf_pkg;

	// Sample and fixed-point formats
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 30;
	localparam int DELAY_FRAC     = 8;
	localparam int DELAY_BITS     = SAMPLE_BITS + 16;
	localparam int PROD_SHIFT     = COEF_FRAC_BITS - DELAY_FRAC;

	// Field widths
	localparam int FREQ_BITS   = 32;
	localparam int PERIOD_BITS = 32;
	localparam int DAMP_BITS   = 18;
	localparam int GAIN_BITS   = 17;
	localparam int GAIN_FRAC   = 16;

	// Configuration port
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SAMPLE_PERIOD = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DAMPING       = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_FLOOR    = 2'd2;
	localparam logic [PERIOD_BITS-1:0] SAMPLE_PERIOD_RST = 32'd429497;
	localparam logic [DAMP_BITS-1:0]   DAMPING_RST       = 18'd46341;
	localparam logic [GAIN_BITS-1:0]   GAIN_FLOOR_RST    = 17'd0;

	// Shared multiplier
	localparam int OPND_BITS    = 32;
	localparam int PRODUCT_BITS = 2 * OPND_BITS;

	// Coefficient datapath
	localparam int ONE_POS    = 32;                       // binary point of wt^2, s
	localparam int WT_BITS    = 31;
	localparam int SQ_BITS    = 2 * WT_BITS;
	localparam int P_BITS     = DAMP_BITS + WT_BITS + 1;
	localparam int DEN_BITS   = 63;
	localparam int NUM_BITS   = DEN_BITS + 1;
	localparam int QUOT_BITS  = COEF_FRAC_BITS + 2;
	localparam int COEF_BITS  = QUOT_BITS + 1;
	localparam int ACC_BITS   = DELAY_BITS + 2;
	localparam int DIV_CNT_BITS = $clog2(QUOT_BITS);

	typedef struct packed {
		logic                start;
		logic [NUM_BITS-1:0] num;
		logic [DEN_BITS-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [QUOT_BITS-1:0] quot;
	} div_rsp_t;

	// Round a product magnitude to the delay scale, half away from zero, apply sign
	function automatic logic signed [ACC_BITS-1:0] round_prod(
		input logic [PRODUCT_BITS-1:0] mag,
		input logic                    neg
	);
		logic [PRODUCT_BITS-1:0] sum;
		logic [ACC_BITS-1:0]     r;
		sum = mag + (PRODUCT_BITS'(1) << (PROD_SHIFT - 1));
		r = ACC_BITS'(sum >> PROD_SHIFT);
		if (neg) begin
			r = ACC_BITS'(-r);
		end
		return $signed(r);
	endfunction

	// Clip an accumulator to the delay register range
	function automatic logic signed [DELAY_BITS-1:0] sat_delay(
		input logic signed [ACC_BITS-1:0] v
	);
		logic [ACC_BITS-DELAY_BITS:0] top;
		top = v[ACC_BITS-1:DELAY_BITS-1];
		if (top == '0 || top == '1) begin
			return v[DELAY_BITS-1:0];
		end else if (v[ACC_BITS-1]) begin
			return {1'b1, {(DELAY_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(DELAY_BITS-1){1'b1}}};
		end
	endfunction

endpackage

// ===== rtl/tnf_sample_if.sv =====
// Input request channel of the notch filter: sample and centre frequency.
// Depends on tnf_pkg.
interface tnf_sample_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [tnf_pkg::SAMPLE_BITS-1:0] sample_in;
	logic [tnf_pkg::FREQ_BITS-1:0]          centre_freq;

	modport source (output valid, sample_in, centre_freq, input ready);
	modport sink   (input valid, sample_in, centre_freq, output ready);
endinterface

// ===== rtl/tnf_result_if.sv =====
// Result request channel of the notch filter: filtered sample and clip flag.
// Depends on tnf_pkg.
interface tnf_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [tnf_pkg::SAMPLE_BITS-1:0] filtered_sample;
	logic                                  saturated;

	modport source (output valid, filtered_sample, saturated, input ready);
	modport sink   (input valid, filtered_sample, saturated, output ready);
endinterface

// ===== rtl/tnf_div.sv =====
// Serial restoring divider: floor(num * 2^COEF_FRAC_BITS / den), one quotient
// bit per cycle, for num < 4*den. Depends on tnf_pkg.
module tnf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tnf_pkg::div_req_t req,
	output tnf_pkg::div_rsp_t rsp
);

	logic                                busy_q;
	logic                                done_q;
	logic [tnf_pkg::DIV_CNT_BITS-1:0]    cnt_q;
	logic [tnf_pkg::DEN_BITS-1:0]        rem_q;
	logic [tnf_pkg::DEN_BITS-1:0]        den_q;
	logic [tnf_pkg::QUOT_BITS-1:0]       nbits_q;
	logic [tnf_pkg::QUOT_BITS-1:0]       quot_q;

	logic [tnf_pkg::DEN_BITS:0]          shifted;
	logic [tnf_pkg::DEN_BITS+1:0]        diff;
	logic                                borrow;
	logic                                last_step;

	// Shift in the next numerator bit and trial-subtract the divisor
	always_comb begin
		shifted = {rem_q, nbits_q[tnf_pkg::QUOT_BITS-1]};
		diff    = {1'b0, shifted} - {2'b00, den_q};
		borrow  = diff[tnf_pkg::DEN_BITS+1];
	end

	assign last_step = (cnt_q == tnf_pkg::DIV_CNT_BITS'(tnf_pkg::QUOT_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// Integer part is below four: the top bits alone stay below den
			rem_q   <= {1'b0, req.num[tnf_pkg::NUM_BITS-1:2]};
			den_q   <= req.den;
			nbits_q <= {req.num[1:0], {(tnf_pkg::QUOT_BITS-2){1'b0}}};
			quot_q  <= '0;
		end else if (busy_q) begin
			rem_q   <= borrow ? shifted[tnf_pkg::DEN_BITS-1:0] : diff[tnf_pkg::DEN_BITS-1:0];
			nbits_q <= {nbits_q[tnf_pkg::QUOT_BITS-2:0], 1'b0};
			quot_q  <= {quot_q[tnf_pkg::QUOT_BITS-2:0], ~borrow};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ===== rtl/tunable_notch_filter_top.sv =====
// Tunable notch filter: it takes one sample request at a time and accepts the next
// only after the previous result has gone into the output register. Three serial
// divisions run on the shared restoring divider; the rest runs on one 32x32 multiplier.
// A finished result waits in an output register while the next request is taken.
// Reset (arst_n, asynchronous, low) clears the delay state and output valid and
// loads the register defaults; sample_ch.ready is already high while reset is held.
module tunable_notch_filter_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tnf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [tnf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	tnf_sample_if.sink                           sample_ch,
	tnf_result_if.source                         result_ch
);

	typedef enum logic [4:0] {
		ST_IDLE, ST_MWT, ST_WT, ST_MQ, ST_MP, ST_SUM,
		ST_TDIV, ST_TWAIT, ST_UDIV, ST_UWAIT, ST_BDIV, ST_BWAIT,
		ST_MV, ST_COEF, ST_MA, ST_EXT, ST_Y, ST_MB, ST_MC, ST_ME, ST_UPD
	} state_t;

	localparam int SB = tnf_pkg::SAMPLE_BITS;
	localparam int CB = tnf_pkg::COEF_BITS;
	localparam int AB = tnf_pkg::ACC_BITS;

	state_t state_q;

	// Configuration registers
	logic [tnf_pkg::PERIOD_BITS-1:0] sample_period_q;
	logic [tnf_pkg::DAMP_BITS-1:0]   damping_q;
	logic [tnf_pkg::GAIN_BITS-1:0]   gain_floor_q;

	// Filter state and output register
	logic signed [tnf_pkg::DELAY_BITS-1:0] delay_one_q;
	logic signed [tnf_pkg::DELAY_BITS-1:0] delay_two_q;
	logic                                  out_valid_q;
	logic signed [SB-1:0]                  filtered_q;
	logic                                  saturated_q;

	// Per-item datapath registers
	logic signed [SB-1:0]                  x_q;
	logic [tnf_pkg::FREQ_BITS-1:0]         freq_q;
	logic [tnf_pkg::PRODUCT_BITS-1:0]      mul_q;
	logic                                  mul_neg_q;
	logic [tnf_pkg::WT_BITS-1:0]           wt_q;
	logic [tnf_pkg::SQ_BITS-1:0]           q_q;
	logic [tnf_pkg::P_BITS-1:0]            p_q;
	logic [tnf_pkg::DEN_BITS-1:0]          s_q;
	logic [tnf_pkg::QUOT_BITS-1:0]         t_q;
	logic [tnf_pkg::QUOT_BITS-1:0]         u_q;
	logic [tnf_pkg::QUOT_BITS-1:0]         bmag_q;
	logic signed [CB-1:0]                  ca_q;
	logic signed [CB-1:0]                  cb_q;
	logic signed [CB-1:0]                  cc_q;
	logic signed [CB-1:0]                  ce_q;
	logic signed [AB-1:0]                  ext_q;
	logic signed [AB-1:0]                  acc_one_q;
	logic signed [AB-1:0]                  acc_two_q;
	logic signed [SB-1:0]                  y_q;
	logic                                  clip_q;

	tnf_pkg::div_req_t div_req;
	tnf_pkg::div_rsp_t div_rsp;

	logic [tnf_pkg::OPND_BITS-1:0] mul_a;
	logic [tnf_pkg::OPND_BITS-1:0] mul_b;
	logic                          mul_neg;
	logic                          mul_en;
	logic signed [AB-1:0]          prod_rnd;
	logic                          accept;
	logic                          out_free;
	logic                          bneg;
	logic [tnf_pkg::SQ_BITS-1:0]   one_sq;

	// Magnitudes fed to the shared multiplier
	logic [SB-1:0]                 x_mag;
	logic [SB-1:0]                 y_mag;
	logic signed [SB:0]            d_val;
	logic [SB:0]                   d_mag;
	logic [CB-2:0]                 ca_mag, cb_mag, cc_mag, ce_mag;

	// Output rounding and clipping
	logic                          ext_neg;
	logic [AB-1:0]                 ext_mag;
	logic [AB-1:0]                 y_full;
	logic                          y_over;
	logic signed [SB-1:0]          y_next;

	// Coefficient forming
	logic [tnf_pkg::OPND_BITS-1:0] v_term;

	assign accept   = sample_ch.valid && sample_ch.ready;
	assign out_free = !out_valid_q || result_ch.ready;
	assign one_sq   = tnf_pkg::SQ_BITS'(1) << tnf_pkg::ONE_POS;
	assign bneg     = q_q > one_sq;
	assign prod_rnd = tnf_pkg::round_prod(mul_q, mul_neg_q);

	always_comb begin
		x_mag  = x_q[SB-1] ? SB'(-x_q) : SB'(x_q);
		y_mag  = y_q[SB-1] ? SB'(-y_q) : SB'(y_q);
		d_val  = (SB+1)'(y_q) - (SB+1)'(x_q);
		d_mag  = d_val[SB] ? (SB+1)'(-d_val) : (SB+1)'(d_val);
		ca_mag = ca_q[CB-1] ? (CB-1)'(-ca_q) : (CB-1)'(ca_q);
		cb_mag = cb_q[CB-1] ? (CB-1)'(-cb_q) : (CB-1)'(cb_q);
		cc_mag = cc_q[CB-1] ? (CB-1)'(-cc_q) : (CB-1)'(cc_q);
		ce_mag = ce_q[CB-1] ? (CB-1)'(-ce_q) : (CB-1)'(ce_q);
	end

	// Operand select for the shared multiplier
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		mul_en  = 1'b1;
		case (state_q)
			ST_MWT: begin
				mul_a = freq_q;
				mul_b = sample_period_q;
			end
			ST_MQ: begin
				mul_a = tnf_pkg::OPND_BITS'(wt_q);
				mul_b = tnf_pkg::OPND_BITS'(wt_q);
			end
			ST_MP: begin
				mul_a = tnf_pkg::OPND_BITS'(damping_q);
				mul_b = tnf_pkg::OPND_BITS'(wt_q);
			end
			ST_MV: begin
				mul_a = tnf_pkg::OPND_BITS'(gain_floor_q);
				mul_b = tnf_pkg::OPND_BITS'(u_q);
			end
			ST_MA: begin
				mul_a   = tnf_pkg::OPND_BITS'(x_mag);
				mul_b   = tnf_pkg::OPND_BITS'(ca_mag);
				mul_neg = x_q[SB-1] ^ ca_q[CB-1];
			end
			ST_MB: begin
				mul_a   = tnf_pkg::OPND_BITS'(d_mag);
				mul_b   = tnf_pkg::OPND_BITS'(cb_mag);
				mul_neg = d_val[SB] ^ cb_q[CB-1];
			end
			ST_MC: begin
				mul_a   = tnf_pkg::OPND_BITS'(x_mag);
				mul_b   = tnf_pkg::OPND_BITS'(cc_mag);
				mul_neg = x_q[SB-1] ^ cc_q[CB-1];
			end
			ST_ME: begin
				mul_a   = tnf_pkg::OPND_BITS'(y_mag);
				mul_b   = tnf_pkg::OPND_BITS'(ce_mag);
				mul_neg = y_q[SB-1] ^ ce_q[CB-1];
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// Divider request: denominator is always s; numerator chosen per division
	always_comb begin
		div_req.den   = s_q;
		div_req.start = 1'b0;
		div_req.num   = '0;
		case (state_q)
			ST_TDIV: begin
				div_req.start = 1'b1;
				div_req.num   = tnf_pkg::NUM_BITS'(one_sq) + tnf_pkg::NUM_BITS'(q_q);
			end
			ST_UDIV: begin
				div_req.start = 1'b1;
				div_req.num   = tnf_pkg::NUM_BITS'(p_q);
			end
			ST_BDIV: begin
				div_req.start = 1'b1;
				div_req.num   = bneg ? tnf_pkg::NUM_BITS'({q_q - one_sq, 1'b0})
				                     : tnf_pkg::NUM_BITS'({one_sq - q_q, 1'b0});
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	tnf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Round the accumulated output to the sample LSB and clip it
	always_comb begin
		ext_neg = ext_q[AB-1];
		ext_mag = ext_neg ? AB'(-ext_q) : AB'(ext_q);
		y_full  = (ext_mag + (AB'(1) << (tnf_pkg::DELAY_FRAC - 1))) >> tnf_pkg::DELAY_FRAC;
		y_over  = ext_neg ? (y_full > (AB'(1) << (SB - 1)))
		                  : (y_full >= (AB'(1) << (SB - 1)));
		if (y_over) begin
			y_next = ext_neg ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
		end else begin
			y_next = ext_neg ? SB'(-y_full[SB-1:0]) : y_full[SB-1:0];
		end
	end

	// Gain-floor term, rounded half up from Q1.16 x coefficient
	assign v_term = tnf_pkg::OPND_BITS'((mul_q + (tnf_pkg::PRODUCT_BITS'(1)
	                << (tnf_pkg::GAIN_FRAC - 1))) >> tnf_pkg::GAIN_FRAC);

	// Sequencer, configuration, filter state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			sample_period_q <= tnf_pkg::SAMPLE_PERIOD_RST;
			damping_q       <= tnf_pkg::DAMPING_RST;
			gain_floor_q    <= tnf_pkg::GAIN_FLOOR_RST;
			delay_one_q     <= '0;
			delay_two_q     <= '0;
			out_valid_q     <= 1'b0;
			filtered_q      <= '0;
			saturated_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tnf_pkg::REG_SAMPLE_PERIOD: sample_period_q <= cfg_data;
					tnf_pkg::REG_DAMPING:       damping_q <= cfg_data[tnf_pkg::DAMP_BITS-1:0];
					tnf_pkg::REG_GAIN_FLOOR:    gain_floor_q <= cfg_data[tnf_pkg::GAIN_BITS-1:0];
					default: begin
						// drop writes to unmapped indexes
					end
				endcase
			end

			// the update step refills the output register itself
			if (result_ch.valid && result_ch.ready && state_q != ST_UPD) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE:  if (accept) state_q <= ST_MWT;
				ST_MWT:   state_q <= ST_WT;
				ST_WT:    state_q <= ST_MQ;
				ST_MQ:    state_q <= ST_MP;
				ST_MP:    state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_TDIV;
				ST_TDIV:  state_q <= ST_TWAIT;
				ST_TWAIT: if (div_rsp.done) state_q <= ST_UDIV;
				ST_UDIV:  state_q <= ST_UWAIT;
				ST_UWAIT: if (div_rsp.done) state_q <= ST_BDIV;
				ST_BDIV:  state_q <= ST_BWAIT;
				ST_BWAIT: if (div_rsp.done) state_q <= ST_MV;
				ST_MV:    state_q <= ST_COEF;
				ST_COEF:  state_q <= ST_MA;
				ST_MA:    state_q <= ST_EXT;
				ST_EXT:   state_q <= ST_Y;
				ST_Y:     state_q <= ST_MB;
				ST_MB:    state_q <= ST_MC;
				ST_MC:    state_q <= ST_ME;
				ST_ME:    state_q <= ST_UPD;
				ST_UPD: begin
					// hold until the output register can take the result
					if (out_free) begin
						delay_one_q <= tnf_pkg::sat_delay(acc_one_q);
						delay_two_q <= tnf_pkg::sat_delay(acc_two_q - prod_rnd);
						filtered_q  <= y_q;
						saturated_q <= clip_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, loaded by step
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= sample_ch.sample_in;
			freq_q <= sample_ch.centre_freq;
		end
		if (mul_en) begin
			mul_q     <= mul_a * mul_b;
			mul_neg_q <= mul_neg;
		end
		case (state_q)
			ST_WT: begin
				// wt = round(freq*Ts / 2^33), half up
				wt_q <= tnf_pkg::WT_BITS'((mul_q + (tnf_pkg::PRODUCT_BITS'(1)
				        << tnf_pkg::ONE_POS)) >> (tnf_pkg::ONE_POS + 1));
			end
			ST_MP: begin
				q_q <= mul_q[tnf_pkg::SQ_BITS-1:0];
			end
			ST_SUM: begin
				p_q <= {mul_q[tnf_pkg::P_BITS-2:0], 1'b0};
				s_q <= tnf_pkg::DEN_BITS'(one_sq) + tnf_pkg::DEN_BITS'(q_q)
				     + tnf_pkg::DEN_BITS'({mul_q[tnf_pkg::P_BITS-2:0], 1'b0});
			end
			ST_TWAIT: if (div_rsp.done) t_q <= div_rsp.quot;
			ST_UWAIT: if (div_rsp.done) u_q <= div_rsp.quot;
			ST_BWAIT: if (div_rsp.done) bmag_q <= div_rsp.quot;
			ST_COEF: begin
				ca_q <= CB'(t_q) + CB'(v_term);
				cc_q <= CB'(t_q) - CB'(v_term);
				ce_q <= CB'(t_q) - CB'(u_q);
				cb_q <= bneg ? CB'(-CB'(bmag_q)) : CB'(bmag_q);
			end
			ST_EXT: begin
				ext_q <= prod_rnd + AB'(delay_one_q);
			end
			ST_Y: begin
				y_q    <= y_next;
				clip_q <= y_over;
			end
			ST_MC: begin
				acc_one_q <= prod_rnd + AB'(delay_two_q);
			end
			ST_ME: begin
				acc_two_q <= prod_rnd;
			end
			default: begin
				// hold
			end
		endcase
	end

	assign sample_ch.ready           = (state_q == ST_IDLE);
	assign result_ch.valid           = out_valid_q;
	assign result_ch.filtered_sample = filtered_q;
	assign result_ch.saturated       = saturated_q;

	// A new result only ever comes from the final update step
	a_out_from_upd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_ch.valid) |-> $past(state_q == ST_UPD))
		else $error("result valid rose outside the update step");

	// No request is taken while the divider is still iterating
	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ch.ready |-> !div_rsp.busy)
		else $error("input ready while divider busy");

	// Divider completion lands only in a wait step
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_TWAIT || state_q == ST_UWAIT || state_q == ST_BWAIT))
		else $error("divider finished outside a wait step");

	// A clipped result sits at one end of the sample range
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && result_ch.saturated) |->
		(result_ch.filtered_sample == {1'b0, {(SB-1){1'b1}}} ||
		 result_ch.filtered_sample == {1'b1, {(SB-1){1'b0}}}))
		else $error("saturated flag set on an in-range sample");

endmodule

// ===== sim/tunable_notch_filter_checker.sv =====
// Scoreboard for the tunable notch filter: mirrors the register file and the
// fixed-point filter arithmetic, predicts every result and compares it.
// Depends on tnf_pkg, tnf_sample_if and tnf_result_if.
module tunable_notch_filter_checker
	import tnf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	tnf_sample_if                     sample_ch,
	tnf_result_if                     result_ch,
	output int                        mismatch_count,
	output int                        outstanding,
	output int                        results_seen,
	output int                        clipped_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int           REPORT_LIMIT = 10;
	localparam logic [63:0]  UNITY        = 64'd1 << ONE_POS;
	localparam logic [127:0] PRODUCT_CAP  = 128'd1 << 62;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          clip;
	} notch_out_t;

	logic [PERIOD_BITS-1:0] ts_q32;
	logic [DAMP_BITS-1:0]   damp_q16;
	logic [GAIN_BITS-1:0]   floor_q16;
	longint                 w1_state;
	longint                 w2_state;
	notch_out_t             pending_out[$];

	// floor(num * 2^COEF_FRAC_BITS / den), as the restoring divider leaves it
	function automatic logic [63:0] frac_quotient(input logic [63:0] num, input logic [63:0] den);
		logic [127:0] wide;
		wide = 128'(num) << COEF_FRAC_BITS;
		wide = wide / 128'(den);
		return wide[63:0];
	endfunction

	// Sample times coefficient, rounded half away from zero onto the delay scale
	function automatic longint scale_product(input longint a, input longint b);
		logic [63:0]  ua;
		logic [63:0]  ub;
		logic [127:0] full;
		logic         neg;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? -a : a;
		ub = (b < 0) ? -b : b;
		full = 128'(ua) * 128'(ub);
		full = (full + (128'd1 << (PROD_SHIFT - 1))) >> PROD_SHIFT;
		if (full > PRODUCT_CAP) begin
			full = PRODUCT_CAP;
		end
		return neg ? -$signed(full[63:0]) : $signed(full[63:0]);
	endfunction

	function automatic longint clamp(input longint v, input int bits, output logic hit);
		longint top_val;
		longint bot_val;
		top_val = (longint'(1) << (bits - 1)) - 1;
		bot_val = -top_val - 1;
		hit = 1'b0;
		if (v > top_val) begin
			hit = 1'b1;
			return top_val;
		end
		if (v < bot_val) begin
			hit = 1'b1;
			return bot_val;
		end
		return v;
	endfunction

	// Derive the coefficients for this frequency, run one filter section step
	// and queue the output sample it must produce.
	function automatic void advance_filter(input logic signed [SAMPLE_BITS-1:0] sample,
			input logic [FREQ_BITS-1:0] freq);
		logic [63:0] prod, wt, sq, pw, r, s, t, u, bmag, v, mag;
		longint      ka, kb, kc, ke, x, acc, y, w1_next, w2_next;
		logic        bneg, clip, unused;
		notch_out_t  nxt;
		prod = 64'(freq) * 64'(ts_q32);
		wt = (prod + UNITY) >> 33;
		sq = wt * wt;
		pw = (64'(damp_q16) * wt) << 1;
		r = UNITY + sq;
		s = r + pw;
		t = frac_quotient(r, s);
		u = frac_quotient(pw, s);
		bneg = sq > UNITY;
		bmag = frac_quotient((bneg ? sq - UNITY : UNITY - sq) << 1, s);
		v = (64'(floor_q16) * u + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
		ka = longint'(t) + longint'(v);
		kb = bneg ? -longint'(bmag) : longint'(bmag);
		kc = longint'(t) - longint'(v);
		ke = longint'(t) - longint'(u);

		x = sample;
		acc = scale_product(x, ka) + w1_state;
		mag = (acc < 0) ? 64'(-acc) : 64'(acc);
		mag = (mag + (64'd1 << (DELAY_FRAC - 1))) >> DELAY_FRAC;
		y = (acc < 0) ? -longint'(mag) : longint'(mag);
		y = clamp(y, SAMPLE_BITS, clip);

		w1_next = clamp(scale_product(y - x, kb) + w2_state, DELAY_BITS, unused);
		w2_next = clamp(scale_product(x, kc) - scale_product(y, ke), DELAY_BITS, unused);
		w1_state = w1_next;
		w2_state = w2_next;

		nxt.sample = SAMPLE_BITS'(y);
		nxt.clip = clip;
		pending_out.push_back(nxt);
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		notch_out_t want;
		if (!arst_n) begin
			ts_q32 = SAMPLE_PERIOD_RST;
			damp_q16 = DAMPING_RST;
			floor_q16 = GAIN_FLOOR_RST;
			w1_state = 0;
			w2_state = 0;
			pending_out.delete();
			mismatch_count = 0;
			outstanding = 0;
			results_seen = 0;
			clipped_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SAMPLE_PERIOD: ts_q32 = cfg_data[PERIOD_BITS-1:0];
					REG_DAMPING:       damp_q16 = cfg_data[DAMP_BITS-1:0];
					REG_GAIN_FLOOR:    floor_q16 = cfg_data[GAIN_BITS-1:0];
					default: ;
				endcase
			end
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (pending_out.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("unexpected result: sample %0d clip %0b",
							$signed(result_ch.filtered_sample), result_ch.saturated);
					end
				end else begin
					want = pending_out.pop_front();
					if (want.clip) begin
						clipped_seen++;
					end
					if (result_ch.filtered_sample !== want.sample ||
							result_ch.saturated !== want.clip) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_LIMIT) begin
							$display("result %0d: expected sample %0d clip %0b, got sample %0d clip %0b",
								results_seen, $signed(want.sample), want.clip,
								$signed(result_ch.filtered_sample), result_ch.saturated);
						end
					end
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				advance_filter(sample_ch.sample_in, sample_ch.centre_freq);
			end
			outstanding = pending_out.size();
		end
	end

endmodule

// ===== sim/tunable_notch_filter_top_test.sv =====
// Top of the notch filter testbench: clock, reset, register programming,
// sample traffic, output back-pressure and the final verdict.
// Depends on tnf_pkg, both channel interfaces, the block and its checker.
module tunable_notch_filter_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tnf_pkg::*;

	localparam int ITEM_TARGET    = 1500;
	localparam int RESET_CYCLES   = 6;
	localparam int HOLD_CYCLES    = 800;
	localparam int HOLD_AT_FIRST  = 200;
	localparam int HOLD_AT_SECOND = 900;
	localparam int DRAIN_CYCLES   = 150;

	// Index with no register behind it; writes to it must change nothing
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

	localparam logic signed [SAMPLE_BITS-1:0] X_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] X_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// With the reset sample period: about 50 Hz, wt of exactly one, and above it
	localparam logic [FREQ_BITS-1:0] F_MAINS    = 32'd314 << 16;
	localparam logic [FREQ_BITS-1:0] F_UNITY_WT = 32'd1310720000;
	localparam logic [FREQ_BITS-1:0] F_HIGH     = 32'd2000000000;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;

	int mismatch_count;
	int outstanding;
	int results_seen;
	int clipped_seen;

	int                     samples_sent;
	int                     burst_left;
	int                     phases_run;
	logic [PERIOD_BITS-1:0] ts_now;

	tnf_sample_if sample_ch();
	tnf_result_if result_ch();

	tunable_notch_filter_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	tunable_notch_filter_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample_ch      (sample_ch),
		.result_ch      (result_ch),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding),
		.results_seen   (results_seen),
		.clipped_seen   (clipped_seen)
	);

	always #10 clk = ~clk;

	// Drive one register write; the caller lowers cfg_we after the last one
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Offer one sample request and hold it until the block takes it. Requests
	// go out in bursts; between bursts the sender may pause for a random gap,
	// which moves the next offer across every phase of the block's work.
	task automatic offer(input logic signed [SAMPLE_BITS-1:0] x,
			input logic [FREQ_BITS-1:0] f);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 250);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			if (gap > 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sample_ch.valid <= 1'b1;
		sample_ch.sample_in <= x;
		sample_ch.centre_freq <= f;
		do @(posedge clk); while (!sample_ch.ready);
		samples_sent++;
	endtask

	// Drop the request line and wait until every predicted result has come back,
	// so the block is idle and registers may be rewritten.
	task automatic settle();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// First settings hit the extremes: zero period (the filter passes the input),
	// full-scale period with no damping, unit period with maximum damping.
	// Later ones are random, with junk above each register's width.
	task automatic program_regs(input int phase);
		logic [PERIOD_BITS-1:0] ts;
		logic [DAMP_BITS-1:0]   dmp;
		logic [GAIN_BITS-1:0]   gfl;
		case (phase)
			1: begin
				ts = '0;
				dmp = '1;
				gfl = '1;
			end
			2: begin
				ts = '1;
				dmp = '0;
				gfl = '0;
			end
			3: begin
				ts = 32'd1;
				dmp = '1;
				gfl = 17'd65536;
			end
			default: begin
				ts = ($urandom_range(0, 2) == 0) ? SAMPLE_PERIOD_RST + $urandom_range(0, 4095)
					: $urandom >> $urandom_range(0, 31);
				if (ts == '0) begin
					ts = 32'd1;
				end
				dmp = ($urandom_range(0, 3) == 0) ? DAMPING_RST : DAMP_BITS'($urandom);
				case ($urandom_range(0, 4))
					0:       gfl = '0;
					1:       gfl = 17'd65536;
					2:       gfl = GAIN_BITS'($urandom_range(65537, 131071));
					default: gfl = GAIN_BITS'($urandom_range(0, 65536));
				endcase
			end
		endcase
		write_reg(REG_SAMPLE_PERIOD, ts);
		write_reg(REG_DAMPING, {(CFG_DATA_BITS-DAMP_BITS)'($urandom), dmp});
		write_reg(REG_GAIN_FLOOR, {(CFG_DATA_BITS-GAIN_BITS)'($urandom), gfl});
		if (phase == 4 || $urandom_range(0, 3) == 0) begin
			write_reg(REG_SPARE, $urandom);
		end
		cfg_we <= 1'b0;
		ts_now = ts;
	endtask

	// Mostly aim the notch so that wt lands between about 0.016 and 16
	function automatic logic [FREQ_BITS-1:0] pick_centre(input logic [PERIOD_BITS-1:0] ts);
		logic [63:0] f;
		if (ts == '0 || $urandom_range(0, 3) == 0) begin
			return $urandom >> $urandom_range(0, 31);
		end
		f = ((64'd1 << 33) * 64'($urandom_range(1 << 10, 1 << 20))) / 64'(ts);
		return (f > 64'hFFFF_FFFF) ? '1 : f[FREQ_BITS-1:0];
	endfunction

	function automatic logic [FREQ_BITS-1:0] rand_freq(input logic [FREQ_BITS-1:0] base);
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return '1;
			2, 3:    return $urandom;
			4:       return $urandom >> $urandom_range(0, 31);
			default: return base;
		endcase
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0:       return X_MAX;
			1:       return X_MIN;
			2, 3:    return SAMPLE_BITS'($urandom_range(0, 511)) - SAMPLE_BITS'(256);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		logic [FREQ_BITS-1:0] base;
		int                   count;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_SAMPLE_PERIOD;
		cfg_data <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.sample_in <= '0;
		sample_ch.centre_freq <= '0;
		samples_sent = 0;
		burst_left = 0;
		phases_run = 1;
		ts_now = SAMPLE_PERIOD_RST;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part under reset settings: zero frequency passes the input,
		// full-scale samples and frequency, wt of exactly one (b is zero),
		// wt above one (b turns negative), then a Nyquist-rate square wave.
		offer(X_MAX, '0);
		offer(X_MIN, '0);
		offer('0, F_MAINS);
		offer(X_MAX, F_MAINS);
		offer(X_MIN, F_MAINS);
		offer(SAMPLE_BITS'(1), '1);
		offer(-SAMPLE_BITS'(1), '1);
		offer(X_MAX, '1);
		offer(X_MIN, '1);
		offer(SAMPLE_BITS'(4000000), F_UNITY_WT);
		offer(-SAMPLE_BITS'(4000000), F_UNITY_WT);
		offer(X_MAX, F_HIGH);
		offer(X_MIN, F_HIGH);
		for (int i = 0; i < 8; i++) begin
			offer(i[0] ? X_MIN : X_MAX, F_MAINS);
		end
		settle();

		// Random part: one register setting per phase, a steady notch frequency
		// with the odd retune and stray value, random sample content.
		for (int p = 1; samples_sent < ITEM_TARGET; p++) begin
			program_regs(p);
			phases_run++;
			base = pick_centre(ts_now);
			count = $urandom_range(90, 180);
			repeat (count) begin
				if ($urandom_range(0, 49) == 0) begin
					base = pick_centre(ts_now);
				end
				offer(rand_sample(), rand_freq(base));
			end
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("ran %0d samples through %0d register settings, zero and full-scale periods included",
			samples_sent, phases_run);
		$display("compared %0d results, %0d of them clipped; %0d mismatches, %0d never returned",
			results_seen, clipped_seen, mismatch_count, outstanding);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Result side: switch between stall patterns chosen at random, and twice hold off
	// for a long stretch so the output register fills and the block has to stall its
	// sample input.
	initial begin : receiver
		rx_mode_t mode;
		int       left;
		int       taken;
		int       holds;
		result_ch.ready <= 1'b0;
		mode = RX_OPEN;
		left = 0;
		taken = 0;
		holds = 0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				taken++;
			end
			if (holds < 2 && taken >= (holds == 0 ? HOLD_AT_FIRST : HOLD_AT_SECOND)) begin
				holds++;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					left = $urandom_range(20, 400);
				end
				left--;
				case (mode)
					RX_OPEN:   result_ch.ready <= 1'b1;
					RX_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: result_ch.ready <= ($urandom_range(0, 7) == 0);
					RX_TOGGLE: result_ch.ready <= ~result_ch.ready;
				endcase
			end
		end
	end

	// Hard stop well beyond the slowest legal run
	initial begin : watchdog
		#60ms;
		$display("simulation failed");
		$finish;
	end

endmodule
